### design/sar_pkg.sv
// ----------------------------------------------------------------------------
// sar_pkg
// Shared types and constants for the segment afterglow refresher.
// ----------------------------------------------------------------------------
package sar_pkg;

    localparam int COLUMNS  = 8;
    localparam int SEGMENTS = 16;
    localparam int GLOW_W   = 16;
    localparam int CFG_W    = 16;

    localparam int DEF_GROUPS     = 4;
    localparam int DEF_LEVELS     = 10;
    localparam int DEF_TEXT_DEPTH = 64;

    // item kinds
    localparam logic [2:0] KIND_FONT  = 3'd0;
    localparam logic [2:0] KIND_TEXT  = 3'd1;
    localparam logic [2:0] KIND_DOT   = 3'd2;
    localparam logic [2:0] KIND_LEVEL = 3'd3;
    localparam logic [2:0] KIND_TICK  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_TEXT_OFFSET = 3'd0;
    localparam logic [2:0] CFG_TEXT_LENGTH = 3'd1;
    localparam logic [2:0] CFG_FONT_OFFSET = 3'd2;
    localparam logic [2:0] CFG_DECAY_DIV   = 3'd3;
    localparam logic [2:0] CFG_ATTR_BASE   = 3'd4;

    localparam logic [7:0] COL_BIT    = 8'h80;
    localparam logic [3:0] SLOT_HDR   = 4'd0;
    localparam logic [3:0] SLOT_LAST  = 4'd8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GRP,
        S_FONT,
        S_FLAT,
        S_DIV,
        S_WB,
        S_SRD
    } t_state;

    typedef struct packed {
        logic              start;
        logic [GLOW_W-1:0] dividend;
        logic [GLOW_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GLOW_W-1:0] quotient;
    } t_div_rsp;

endpackage

### design/segment_afterglow_refresh_top.sv
// ----------------------------------------------------------------------------
// segment_afterglow_refresh_top
// 16-segment display refresher with afterglow decay, memory based.
//
//  channel  direction  signals                                   handshake
//  item     in         i_kind i_address i_data_word i_attr_code   start/busy
//                      i_column
//  result   out        o_group o_slot o_data_word_res o_last      o_res_valid
//  config   in         i_cfg_idx i_cfg_data                       i_cfg_we
//
// A tick runs the serial divider once per glow cell, 17 cells per group.
// After reset a clearing pass zeroes the memories; busy stays high meanwhile.
// Results are single cycle strobes; the receiver cannot stall.
// Each glow cell is read and written back before the next is read, so no
// forwarding is needed.
// ----------------------------------------------------------------------------
module segment_afterglow_refresh_top #(
    parameter int GROUPS     = sar_pkg::DEF_GROUPS,
    parameter int LEVELS     = sar_pkg::DEF_LEVELS,
    parameter int TEXT_DEPTH = sar_pkg::DEF_TEXT_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_kind,
    input  logic [7:0]                i_address,
    input  logic [15:0]               i_data_word,
    input  logic [7:0]                i_attr_code,
    input  logic [2:0]                i_column,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [sar_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_res_valid,
    output logic [2:0]                o_group,
    output logic [3:0]                o_slot,
    output logic [23:0]               o_data_word_res,
    output logic                      o_last
);
    import sar_pkg::*;

    localparam int CELLS     = GROUPS * COLUMNS;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SEG_DEPTH = CELLS * SEGMENTS;
    localparam int SEG_AW    = CELL_W + 4;
    localparam int TXT_W     = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CLR_A     = (SEG_DEPTH > 256) ? SEG_DEPTH : 256;
    localparam int CLR_LEN   = (CLR_A > TEXT_DEPTH) ? CLR_A : TEXT_DEPTH;
    localparam int CLR_W     = $clog2(CLR_LEN);

    // configuration registers
    logic [15:0] r_toff;
    logic [6:0]  r_tlen;
    logic [7:0]  r_foff;
    logic [15:0] r_ddiv;
    logic [7:0]  r_abase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toff  <= 16'd0;
            r_tlen  <= 7'd1;
            r_foff  <= 8'd0;
            r_ddiv  <= 16'd2;
            r_abase <= 8'd48;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEXT_OFFSET: r_toff  <= i_cfg_data;
                CFG_TEXT_LENGTH: r_tlen  <= i_cfg_data[6:0];
                CFG_FONT_OFFSET: r_foff  <= i_cfg_data[7:0];
                CFG_DECAY_DIV:   r_ddiv  <= i_cfg_data;
                CFG_ATTR_BASE:   r_abase <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control state
    t_state             r_state, n_state;
    logic [CLR_W-1:0]   r_clr;
    logic [GRP_W-1:0]   r_grp;
    logic [2:0]         r_col;
    logic [3:0]         r_seg;
    logic               r_is_dot;
    logic               r_inwin;
    logic [7:0]         r_tattr;
    logic [15:0]        r_mask;
    logic [GLOW_W-1:0]  r_g;
    logic [GLOW_W-1:0]  r_tgt;
    logic [GLOW_W-1:0]  r_even;

    logic [CELL_W-1:0]  cell_idx;
    logic signed [17:0] tp;
    logic               inwin;
    logic               accept;

    assign accept   = start && !busy;
    assign cell_idx = CELL_W'({r_grp, r_col});
    assign tp       = $signed({{2{r_toff[15]}}, r_toff}) + $signed(18'(cell_idx));
    assign inwin    = !tp[17] && (tp[16:0] < {10'd0, r_tlen}) &&
                      (32'(tp[16:0]) < TEXT_DEPTH);

    // memories: read data registered
    logic [GLOW_W-1:0] seg_mem [SEG_DEPTH];
    logic [GLOW_W-1:0] dglow_mem [CELLS];
    logic [15:0]       font_mem [256];
    logic [15:0]       text_mem [TEXT_DEPTH];
    logic [7:0]        dattr_mem [CELLS];
    logic [15:0]       r_lvl [LEVELS];

    logic              seg_we, dglow_we, font_we, text_we, dattr_we;
    logic [SEG_AW-1:0] seg_wa, seg_ra;
    logic [CELL_W-1:0] dglow_wa, dattr_wa;
    logic [7:0]        font_wa, font_ra;
    logic [TXT_W-1:0]  text_wa;
    logic [GLOW_W-1:0] seg_wd, dglow_wd;
    logic [15:0]       font_wd, text_wd;
    logic [7:0]        dattr_wd;
    logic [GLOW_W-1:0] seg_q, dglow_q;
    logic [15:0]       font_q, text_q;
    logic [7:0]        dattr_q;

    always_ff @(posedge i_clk) begin
        if (seg_we) seg_mem[seg_wa] <= seg_wd;
        seg_q <= seg_mem[seg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (dglow_we) dglow_mem[dglow_wa] <= dglow_wd;
        dglow_q <= dglow_mem[cell_idx];
    end
    always_ff @(posedge i_clk) begin
        if (font_we) font_mem[font_wa] <= font_wd;
        font_q <= font_mem[font_ra];
    end
    always_ff @(posedge i_clk) begin
        if (text_we) text_mem[text_wa] <= text_wd;
        text_q <= text_mem[tp[TXT_W-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (dattr_we) dattr_mem[dattr_wa] <= dattr_wd;
        dattr_q <= dattr_mem[cell_idx];
    end

    // level table in flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) r_lvl[i] <= 16'd0;
        end else if (accept && i_kind == KIND_LEVEL && 32'(i_address) < LEVELS) begin
            r_lvl[i_address[LVL_W-1:0]] <= i_data_word;
        end
    end

    // attribute to level lookup
    logic [7:0]        lk_attr, lk_diff;
    logic [GLOW_W-1:0] lk_level;
    assign lk_attr  = (r_state == S_FONT) ? dattr_q : r_tattr;
    assign lk_diff  = lk_attr - r_abase;
    assign lk_level = (lk_attr >= r_abase && 32'(lk_diff) < LEVELS) ?
                      r_lvl[lk_diff[LVL_W-1:0]] : '0;

    // decay divider, zero divisor acts as one
    t_div_req div_req;
    t_div_rsp div_rsp;
    sar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // glow update
    logic [GLOW_W-1:0] g_dec, g_new;
    assign g_dec = r_g - div_rsp.quotient;
    assign g_new = (g_dec < r_tgt) ? r_tgt : g_dec;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    // next state and memory controls
    always_comb begin
        n_state          = r_state;
        busy             = (r_state != S_IDLE);
        seg_we           = 1'b0;
        dglow_we         = 1'b0;
        font_we          = 1'b0;
        text_we          = 1'b0;
        dattr_we         = 1'b0;
        seg_wa           = {cell_idx, r_seg};
        seg_ra           = {cell_idx, r_seg};
        seg_wd           = g_new;
        dglow_wa         = cell_idx;
        dglow_wd         = g_new;
        font_wa          = i_address;
        font_wd          = i_data_word;
        font_ra          = text_q[7:0] + r_foff;
        text_wa          = i_address[TXT_W-1:0];
        text_wd          = {i_attr_code, i_data_word[7:0]};
        dattr_wa         = i_address[CELL_W-1:0];
        dattr_wd         = i_attr_code;
        div_req.start    = 1'b0;
        div_req.dividend = r_g;
        div_req.divisor  = (r_ddiv == 16'd0) ? 16'd1 : r_ddiv;
        case (r_state)
            S_CLEAR: begin
                seg_wa   = r_clr[SEG_AW-1:0];
                seg_wd   = '0;
                seg_we   = 32'(r_clr) < SEG_DEPTH;
                dglow_wa = r_clr[CELL_W-1:0];
                dglow_wd = '0;
                dglow_we = 32'(r_clr) < CELLS;
                dattr_wa = r_clr[CELL_W-1:0];
                dattr_wd = '0;
                dattr_we = 32'(r_clr) < CELLS;
                font_wa  = r_clr[7:0];
                font_wd  = '0;
                font_we  = 32'(r_clr) < 256;
                text_wa  = r_clr[TXT_W-1:0];
                text_wd  = '0;
                text_we  = 32'(r_clr) < TEXT_DEPTH;
                if (32'(r_clr) == CLR_LEN - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    font_we  = (i_kind == KIND_FONT);
                    text_we  = (i_kind == KIND_TEXT) && (32'(i_address) < TEXT_DEPTH);
                    dattr_we = (i_kind == KIND_DOT) && (32'(i_address) < CELLS);
                    if (i_kind == KIND_TICK) n_state = S_GRP;
                end
            end
            S_GRP:  n_state = S_FONT;
            S_FONT: begin
                div_req.start    = 1'b1;
                div_req.dividend = dglow_q;
                n_state          = S_FLAT;
            end
            S_FLAT: begin
                // segment divide starts as its read data lands
                if (!r_is_dot) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = seg_q;
                end
                n_state = S_DIV;
            end
            S_DIV:  if (div_rsp.done) n_state = S_WB;
            S_WB: begin
                if (r_is_dot) begin
                    dglow_we = 1'b1;
                    n_state  = S_SRD;
                end else begin
                    seg_we = 1'b1;
                    if (r_seg != 4'd15)        n_state = S_SRD;
                    else if (r_grp == '0)      n_state = S_IDLE;
                    else                       n_state = S_GRP;
                end
            end
            S_SRD: begin
                // seg_q is valid next cycle; S_FLAT latches it
                n_state = S_FLAT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col <= i_column;
                r_grp <= GRP_W'(GROUPS - 1);
            end
            S_GRP: begin
                r_inwin  <= inwin;
                r_is_dot <= 1'b1;
            end
            S_FONT: begin
                r_g     <= dglow_q;
                r_tgt   <= lk_level;
                r_tattr <= text_q[15:8];
            end
            S_FLAT: begin
                if (r_is_dot) begin
                    r_mask <= r_inwin ? font_q : 16'd0;
                end else begin
                    r_g   <= seg_q;
                    r_tgt <= r_mask[~r_seg] ? lk_level : '0;
                end
            end
            S_WB: begin
                if (r_is_dot) begin
                    r_is_dot <= 1'b0;
                    r_seg    <= 4'd0;
                end else begin
                    r_seg <= r_seg + 1'b1;
                    if (r_seg == 4'd15) r_grp <= r_grp - 1'b1;
                end
                if (!r_seg[0]) r_even <= g_new;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= (r_state == S_WB) && (r_is_dot || r_seg[0]);
        end
        o_group         <= 3'(r_grp);
        o_slot          <= r_is_dot ? SLOT_HDR : (4'(r_seg[3:1]) + 4'd1);
        o_data_word_res <= r_is_dot ?
                           {8'd0, COL_BIT >> r_col, g_new[15:8]} :
                           {r_even[15:4], g_new[15:4]};
        o_last          <= !r_is_dot && (r_seg == 4'd15) && (r_grp == '0);
    end

    // assertions
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_kind == KIND_TICK |=> busy)
        else $error("tick did not start work");
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_kind != KIND_TICK |=> !o_res_valid)
        else $error("result after a write item");
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_last |-> o_group == 3'd0 && o_slot == SLOT_LAST)
        else $error("last word misplaced");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_slot <= SLOT_LAST)
        else $error("slot out of range");

endmodule

### design/sar_div.sv
// ----------------------------------------------------------------------------
// sar_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sar_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sar_pkg::t_div_req i_req,
    output sar_pkg::t_div_rsp o_rsp
);
    import sar_pkg::*;

    localparam int CNT_W = $clog2(GLOW_W + 1);

    logic [GLOW_W:0]   r_rem;
    logic [GLOW_W-1:0] r_quo;
    logic [GLOW_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic [GLOW_W:0]   rem_sh;
    logic              fits;

    // trial subtract
    assign rem_sh = {r_rem[GLOW_W-1:0], r_quo[GLOW_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(GLOW_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[GLOW_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
